// File: rtl/pldc_pkg.sv
// Package: shared types, constants and digit helpers for the press-length counter.
`timescale 1ns / 1ps
`default_nettype none
package pldc_pkg;

  localparam int RegWidth   = 20;
  localparam int PressWidth = 21;
  localparam int CountWidth = 14;
  localparam int NumDigits  = 4;
  localparam int PosWidth   = 2;

  typedef logic [RegWidth-1:0]   reg_t;
  typedef logic [PressWidth-1:0] press_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [3:0]            digit_t;
  typedef logic [PosWidth-1:0]   pos_t;
  // index 0 is the thousands digit
  typedef digit_t [NumDigits-1:0] digits_t;

  localparam pos_t   REG_LONG_THRESHOLD = 2'd0;
  localparam pos_t   REG_REPEAT_RELOAD  = 2'd1;
  localparam pos_t   REG_SHORT_MIN      = 2'd2;
  localparam pos_t   REG_SHORT_MAX      = 2'd3;

  localparam reg_t   LongThresholdReset = 20'd200000;
  localparam reg_t   RepeatReloadReset  = 20'd150000;
  localparam reg_t   ShortMinReset      = 20'd500;
  localparam reg_t   ShortMaxReset      = 20'd50000;

  localparam count_t CountTop = 14'd9999;
  localparam press_t PressMax = {PressWidth{1'b1}};
  localparam digit_t DigitTop = 4'd9;

  typedef struct packed {
    reg_t long_press_threshold;
    reg_t repeat_reload_value;
    reg_t short_press_min;
    reg_t short_press_max;
  } cfg_t;

  typedef struct packed {
    pos_t   digit_position;
    digit_t digit_value;
    count_t count_value;
    logic   counting_up;
  } result_t;

  function automatic digits_t bcd_inc(input digits_t d);
    digits_t r;
    logic    carry;
    r     = d;
    carry = 1'b1;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (carry) begin
        if (d[i] >= DigitTop) begin
          r[i] = 4'd0;
        end else begin
          r[i]  = d[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic digits_t bcd_dec(input digits_t d);
    digits_t r;
    logic    borrow;
    r      = d;
    borrow = 1'b1;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (borrow) begin
        if (d[i] == 4'd0) begin
          r[i] = DigitTop;
        end else begin
          r[i]   = d[i] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pldc_if.sv
// Interfaces: tick input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface pldc_tick_if;
  logic valid;
  logic ready;
  logic key_down;
  modport source (output valid, output key_down, input ready);
  modport sink   (input valid, input key_down, output ready);
endinterface

interface pldc_result_if;
  logic              valid;
  logic              ready;
  pldc_pkg::pos_t    digit_position;
  pldc_pkg::digit_t  digit_value;
  pldc_pkg::count_t  count_value;
  logic              counting_up;
  modport source (output valid, output digit_position, output digit_value,
                  output count_value, output counting_up, input ready);
  modport sink   (input valid, input digit_position, input digit_value,
                  input count_value, input counting_up, output ready);
endinterface
`default_nettype wire

// File: rtl/press_length_updown_decimal_counter.sv
// Top level: input stage, counter core, result register and config bank.
// Path: a tick is captured in the input stage register, and its result is then
// registered in the result register that drives result_ch.
// Throughput: one tick per cycle; a stalled result holds tick_ch once both registers are full.
// The press counter, count and digits update in a single pass per tick.
// Reset (rst, synchronous): count 0, direction up, scan position 0,
// registers at their default thresholds, both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module press_length_updown_decimal_counter (
  input  wire logic           clk,
  input  wire logic           rst,
  pldc_tick_if.sink           tick_ch,
  pldc_result_if.source       result_ch,
  input  wire logic           cfg_we,
  input  wire pldc_pkg::pos_t cfg_index,
  input  wire pldc_pkg::reg_t cfg_data
);
  import pldc_pkg::*;

  cfg_t    cfg;
  result_t res, out_data;
  logic    in_valid, in_button, out_valid, advance;

  assign advance       = in_valid && (!out_valid || result_ch.ready);
  assign tick_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick_ch.ready) begin
      in_valid <= tick_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ch.ready && tick_ch.valid) begin
      in_button <= tick_ch.key_down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  pldc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pldc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .key_down (in_button),
    .cfg      (cfg),
    .res      (res)
  );

  assign result_ch.valid          = out_valid;
  assign result_ch.digit_position = out_data.digit_position;
  assign result_ch.digit_value    = out_data.digit_value;
  assign result_ch.count_value    = out_data.count_value;
  assign result_ch.counting_up    = out_data.counting_up;

endmodule
`default_nettype wire

// File: rtl/pldc_cfg.sv
// Configuration register bank with write port.
`timescale 1ns / 1ps
`default_nettype none
module pldc_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire pldc_pkg::pos_t cfg_index,
  input  wire pldc_pkg::reg_t cfg_data,
  output pldc_pkg::cfg_t      cfg
);
  import pldc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_threshold <= LongThresholdReset;
      cfg.repeat_reload_value  <= RepeatReloadReset;
      cfg.short_press_min      <= ShortMinReset;
      cfg.short_press_max      <= ShortMaxReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_THRESHOLD: cfg.long_press_threshold <= cfg_data;
        REG_REPEAT_RELOAD:  cfg.repeat_reload_value  <= cfg_data;
        REG_SHORT_MIN:      cfg.short_press_min      <= cfg_data;
        REG_SHORT_MAX:      cfg.short_press_max      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/pldc_core.sv
// Counter core: press timing, up/down count, BCD digits and scan position.
`timescale 1ns / 1ps
`default_nettype none
module pldc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            key_down,
  input  wire pldc_pkg::cfg_t  cfg,
  output pldc_pkg::result_t    res
);
  import pldc_pkg::*;

  press_t  press_ticks, press_ticks_next, press_inc;
  count_t  decimal_count, decimal_count_next;
  logic    direction_up, direction_up_next;
  pos_t    scan_position;
  digits_t shown_digits, shown_digits_next;
  logic    step;

  always_comb begin
    press_inc          = (press_ticks != PressMax) ? press_ticks + press_t'(1) : press_ticks;
    step               = key_down && (press_inc > {1'b0, cfg.long_press_threshold});
    press_ticks_next   = press_ticks;
    decimal_count_next = decimal_count;
    direction_up_next  = direction_up;
    shown_digits_next  = shown_digits;
    if (key_down) begin
      press_ticks_next = press_inc;
      if (step) begin
        if (direction_up) begin
          decimal_count_next = (decimal_count >= CountTop) ? '0 : decimal_count + count_t'(1);
          shown_digits_next  = bcd_inc(shown_digits);
        end else begin
          decimal_count_next = (decimal_count == '0) ? CountTop : decimal_count - count_t'(1);
          shown_digits_next  = bcd_dec(shown_digits);
        end
        press_ticks_next = {1'b0, cfg.repeat_reload_value};
      end
    end else begin
      if ((press_ticks > {1'b0, cfg.short_press_min}) &&
          (press_ticks < {1'b0, cfg.short_press_max})) begin
        direction_up_next = !direction_up;
      end
      press_ticks_next = '0;
    end
    res.digit_position = scan_position;
    res.digit_value    = shown_digits[scan_position];
    res.count_value    = decimal_count_next;
    res.counting_up    = direction_up_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks   <= '0;
      decimal_count <= '0;
      direction_up  <= 1'b1;
      scan_position <= '0;
      shown_digits  <= '0;
    end else if (advance) begin
      press_ticks   <= press_ticks_next;
      decimal_count <= decimal_count_next;
      direction_up  <= direction_up_next;
      scan_position <= scan_position + pos_t'(1);
      shown_digits  <= shown_digits_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    decimal_count <= CountTop)
    else $error("count out of range");

  a_digits_match: assert property (@(posedge clk) disable iff (rst)
    decimal_count == (count_t'(shown_digits[0]) * count_t'(1000) +
                      count_t'(shown_digits[1]) * count_t'(100) +
                      count_t'(shown_digits[2]) * count_t'(10) +
                      count_t'(shown_digits[3])))
    else $error("digits disagree with count");

  a_dir_hold_pressed: assert property (@(posedge clk) disable iff (rst)
    advance && key_down |=> $stable(direction_up))
    else $error("direction changed while held");

  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> scan_position == $past(scan_position) + pos_t'(1))
    else $error("scan position did not advance");

endmodule
`default_nettype wire

// File: tb/pldc_display_checker.sv
// Checker: watches the tick, result and register ports, predicts each display tick and compares.
`timescale 1ns / 1ps
`default_nettype none
module pldc_display_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  pldc_tick_if                tick_ch,
  pldc_result_if              result_ch,
  input  wire logic           cfg_we,
  input  wire pldc_pkg::pos_t cfg_index,
  input  wire pldc_pkg::reg_t cfg_data,
  output int unsigned         mismatches,
  output int unsigned         outstanding,
  output int unsigned         ticks_checked,
  output int unsigned         count_steps,
  output int unsigned         direction_flips
);
  import pldc_pkg::*;

  cfg_t    thresholds;
  press_t  press_len;
  count_t  count_now;
  logic    going_up;
  pos_t    scan_at;
  digits_t digit_store;
  result_t display_due[$];

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned wanted);
    if (mismatches < 40) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
    end
    mismatches++;
  endtask

  task automatic advance_counter(input logic pressed);
    result_t r;
    r.digit_position = scan_at;
    r.digit_value    = digit_store[scan_at];
    scan_at          = scan_at + 1'b1;
    if (pressed) begin
      if (press_len != PressMax) begin
        press_len = press_len + 1'b1;
      end
      if (press_len > {1'b0, thresholds.long_press_threshold}) begin
        if (going_up) begin
          count_now = (count_now >= CountTop) ? count_t'(0) : count_now + 1'b1;
        end else begin
          count_now = (count_now == 0 || count_now > CountTop) ? CountTop : count_now - 1'b1;
        end
        digit_store[3] = digit_t'(count_now % 10);
        digit_store[2] = digit_t'((count_now / 10) % 10);
        digit_store[1] = digit_t'((count_now / 100) % 10);
        digit_store[0] = digit_t'((count_now / 1000) % 10);
        press_len      = {1'b0, thresholds.repeat_reload_value};
        count_steps++;
      end
    end else begin
      if (press_len > {1'b0, thresholds.short_press_min} &&
          press_len < {1'b0, thresholds.short_press_max}) begin
        going_up = ~going_up;
        direction_flips++;
      end
      press_len = '0;
    end
    r.count_value = count_now;
    r.counting_up = going_up;
    display_due.push_back(r);
  endtask

  task automatic check_display();
    result_t want;
    if (display_due.size() == 0) begin
      flag_mismatch("unexpected transfer, count_value", 32'(result_ch.count_value), 0);
      return;
    end
    want = display_due.pop_front();
    if (result_ch.digit_position !== want.digit_position) begin
      flag_mismatch("digit_position", 32'(result_ch.digit_position),
                    32'(want.digit_position));
    end
    if (result_ch.digit_value !== want.digit_value) begin
      flag_mismatch("digit_value", 32'(result_ch.digit_value), 32'(want.digit_value));
    end
    if (result_ch.count_value !== want.count_value) begin
      flag_mismatch("count_value", 32'(result_ch.count_value), 32'(want.count_value));
    end
    if (result_ch.counting_up !== want.counting_up) begin
      flag_mismatch("counting_up", 32'(result_ch.counting_up), 32'(want.counting_up));
    end
    ticks_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thresholds.long_press_threshold = LongThresholdReset;
      thresholds.repeat_reload_value  = RepeatReloadReset;
      thresholds.short_press_min      = ShortMinReset;
      thresholds.short_press_max      = ShortMaxReset;
      press_len   = '0;
      count_now   = '0;
      going_up    = 1'b1;
      scan_at     = '0;
      digit_store = '0;
      display_due.delete();
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        advance_counter(tick_ch.key_down);
      end
      if (result_ch.valid && result_ch.ready) begin
        check_display();
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_THRESHOLD: thresholds.long_press_threshold = cfg_data;
          REG_REPEAT_RELOAD:  thresholds.repeat_reload_value  = cfg_data;
          REG_SHORT_MIN:      thresholds.short_press_min      = cfg_data;
          REG_SHORT_MAX:      thresholds.short_press_max      = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = display_due.size();
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench top: clock, reset, button tick stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pldc_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam reg_t        RegAllOnes = 20'hFFFFF;

  logic clk;
  logic rst;
  logic cfg_we;
  pos_t cfg_index;
  reg_t cfg_data;

  pldc_tick_if   tick_ch ();
  pldc_result_if result_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned ticks_checked;
  int unsigned count_steps;
  int unsigned direction_flips;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned setting_count;
  bit          steady;

  press_length_updown_decimal_counter uut (
    .clk       (clk),
    .rst       (rst),
    .tick_ch   (tick_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pldc_display_checker display_check (
    .clk             (clk),
    .rst             (rst),
    .tick_ch         (tick_ch),
    .result_ch       (result_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .ticks_checked   (ticks_checked),
    .count_steps     (count_steps),
    .direction_flips (direction_flips)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timed out after %0d cycles, %0d results pending", cycle_count, outstanding);
      $display("press_length_updown_decimal_counter verification failed");
      $finish;
    end
  end

  // receiver: stall patterns in runs, plus one long hold-off to back up the block
  initial begin
    int unsigned mode;
    int unsigned run_left;
    bit          held_once;
    mode      = 0;
    run_left  = 0;
    held_once = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && ticks_checked >= 300) begin
        held_once = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (120) @(negedge clk);
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(8, 64);
        end
        run_left--;
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 3) != 0);
          2: result_ch.ready <= run_left[0];
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic offer(input logic pressed);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    tick_ch.valid    <= 1'b1;
    tick_ch.key_down <= pressed;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic press_for(input int unsigned held, input int unsigned released);
    repeat (held) offer(1'b1);
    repeat (released) offer(1'b0);
  endtask

  // drain: drop valid, wait for every transfer to come out, then let the pipe settle
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic program_thresholds(input reg_t thr, input reg_t reload,
                                    input reg_t lo, input reg_t hi);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_THRESHOLD;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= REG_REPEAT_RELOAD;
    cfg_data  <= reload;
    @(negedge clk);
    cfg_index <= REG_SHORT_MIN;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= REG_SHORT_MAX;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin
    int unsigned n;
    int unsigned len;
    int unsigned gap_len;
    reg_t        thr;
    reg_t        lo;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_LONG_THRESHOLD;
    cfg_data         = '0;
    tick_ch.valid    = 1'b0;
    tick_ch.key_down = 1'b0;
    burst_left       = 0;
    steady           = 1'b0;
    setting_count    = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // default thresholds: nothing steps, digits stay at zero
    press_for(2, 2);

    // short window of two or three: toggle down, wrap down, toggle up, wrap up
    program_thresholds(20'd2, 20'd1, 20'd1, 20'd4);
    press_for(2, 1);
    press_for(4, 1);
    press_for(3, 1);

    // reload above threshold: step on every held tick, release lands on the window edge, then just inside it
    program_thresholds(20'd0, RegAllOnes, 20'd0, RegAllOnes);
    press_for(5, 1);
    program_thresholds(20'd0, RegAllOnes - 1'b1, 20'd0, RegAllOnes);
    press_for(2, 1);

    for (int ph = 0; ph < 8; ph++) begin
      thr = reg_t'($urandom_range(0, 10));
      lo  = reg_t'($urandom_range(0, 4));
      case (ph)
        5: begin
          program_thresholds(thr, reg_t'($urandom_range(0, 4)), RegAllOnes, 20'd0);
        end
        6: begin
          program_thresholds(RegAllOnes, reg_t'($urandom_range(0, 8)), 20'd0, RegAllOnes);
        end
        default: begin
          program_thresholds(thr, reg_t'($urandom_range(0, thr + 3)), lo,
                             lo + reg_t'($urandom_range(0, 8)));
        end
      endcase
      steady = (ph == 3);
      n = 0;
      while (n < 100) begin
        if ($urandom_range(0, 9) < 8) begin
          len     = $urandom_range(1, 25);
          gap_len = $urandom_range(1, 3);
          press_for(len, gap_len);
          n += len + gap_len;
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) offer(1'($urandom_range(0, 1)));
          n += len;
        end
      end
    end

    settle();
    repeat (10) @(negedge clk);
    $display("Checked %0d display ticks over %0d threshold settings,", ticks_checked,
             setting_count);
    $display("with %0d count steps, %0d direction changes and one long output stall.",
             count_steps, direction_flips);
    if (mismatches == 0) begin
      $display("press_length_updown_decimal_counter verification clean");
    end else begin
      $display("press_length_updown_decimal_counter verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
